// File: design/rhwf_pkg.sv
// rhwf_pkg: shared types and codes for the right-hand wall follower
// no dependencies; compiled first
`default_nettype none

package rhwf_pkg;

    localparam int HEAD_BITS    = 2;
    localparam int STATUS_BITS  = 3;
    localparam int CFG_IDX_BITS = 2;

    // absolute compass headings, also the wall vector index
    typedef enum logic [HEAD_BITS-1:0] {
        HEAD_UP,
        HEAD_RIGHT,
        HEAD_DOWN,
        HEAD_LEFT
    } t_heading;

    // result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        STAT_ALIGN,
        STAT_MOVED,
        STAT_STUCK,
        STAT_LOOP,
        STAT_FULL,
        STAT_RANGE
    } t_status;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_X,
        REG_START_Y,
        REG_START_HEADING
    } t_cfg_reg;

    // top level sequencer
    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    // control part of the search token walking the cell row
    typedef struct packed {
        logic valid;
        logic hit;
        logic stored;
    } t_tok_ctl;

    // decision from the move logic
    typedef struct packed {
        t_status status;
        logic    record;
        logic    halt;
        logic    fwd_done;
        logic    aligned;
    } t_move_ctl;

    localparam t_heading START_HEADING_RST = HEAD_RIGHT;

endpackage

`default_nettype wire

// File: design/rhwf_if.sv
// rhwf_if: valid/ready channel interfaces (step, result, configuration)
// depends on rhwf_pkg
`default_nettype none

interface rhwf_step_if;
    logic valid;
    logic ready;
    logic wall_up;
    logic wall_right;
    logic wall_down;
    logic wall_left;

    modport source (output valid, output wall_up, output wall_right,
                    output wall_down, output wall_left, input ready);
    modport sink   (input valid, input wall_up, input wall_right,
                    input wall_down, input wall_left, output ready);
endinterface

interface rhwf_res_if #(parameter int COORD_BITS = 8);
    logic                             valid;
    logic                             ready;
    logic [COORD_BITS-1:0]            pos_x;
    logic [COORD_BITS-1:0]            pos_y;
    logic [rhwf_pkg::HEAD_BITS-1:0]   heading;
    logic [rhwf_pkg::STATUS_BITS-1:0] status;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output status, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading,
                    input status, output ready);
endinterface

interface rhwf_cfg_if #(parameter int COORD_BITS = 8);
    logic                              valid;
    logic                              ready;
    logic [rhwf_pkg::CFG_IDX_BITS-1:0] index;
    logic [COORD_BITS-1:0]             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/rhwf_cell.sv
// rhwf_cell: one history cell; stores a visit and checks the passing token
// depends on rhwf_pkg
`default_nettype none

module rhwf_cell #(
    parameter int ENTRY_BITS = 18,
    parameter int CNT_BITS   = 9
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rhwf_pkg::t_tok_ctl    i_ctl,
    input  wire logic [ENTRY_BITS-1:0] i_probe,
    input  wire logic [CNT_BITS-1:0]   i_remain,
    output rhwf_pkg::t_tok_ctl         o_ctl,
    output logic [ENTRY_BITS-1:0]      o_probe,
    output logic [CNT_BITS-1:0]        o_remain
);

    logic [ENTRY_BITS-1:0] r_entry;
    rhwf_pkg::t_tok_ctl    r_ctl;
    logic [ENTRY_BITS-1:0] r_probe;
    logic [CNT_BITS-1:0]   r_remain;

    logic                  w_live;
    logic                  w_match;
    logic                  w_store;
    rhwf_pkg::t_tok_ctl    n_ctl;
    logic [CNT_BITS-1:0]   n_remain;

    // entries ahead of the fill point are compared, the first free one takes the probe
    assign w_live  = i_ctl.valid && !i_ctl.hit && !i_ctl.stored;
    assign w_match = w_live && (i_remain != '0) && (r_entry == i_probe);
    assign w_store = w_live && (i_remain == '0);

    always_comb begin
        n_ctl        = i_ctl;
        n_ctl.hit    = i_ctl.hit | w_match;
        n_ctl.stored = i_ctl.stored | w_store;
        n_remain     = (i_remain != '0) ? (i_remain - CNT_BITS'(1)) : i_remain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe  <= i_probe;
        r_remain <= n_remain;
        if (w_store) begin
            r_entry <= i_probe;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_probe  = r_probe;
    assign o_remain = r_remain;

endmodule

`default_nettype wire

// File: design/rhwf_move.sv
// rhwf_move: alignment and right-hand choice for one step request
// depends on rhwf_pkg
`default_nettype none

module rhwf_move #(
    parameter int COORD_BITS = 8
) (
    input  wire logic [3:0]                     i_walls,
    input  wire logic [COORD_BITS-1:0]          i_x,
    input  wire logic [COORD_BITS-1:0]          i_y,
    input  wire logic [rhwf_pkg::HEAD_BITS-1:0] i_head,
    input  wire logic                           i_fwd_done,
    input  wire logic                           i_aligned,
    output logic [COORD_BITS-1:0]               o_x,
    output logic [COORD_BITS-1:0]               o_y,
    output logic [rhwf_pkg::HEAD_BITS-1:0]      o_head,
    output rhwf_pkg::t_move_ctl                 o_ctl
);

    localparam int HB = rhwf_pkg::HEAD_BITS;

    logic [HB-1:0]         h_p1, h_p2, h_p3;
    logic [HB-1:0]         h_rot, h_base, b_p1, b_p2, b_p3, h_pick, d_step;
    logic                  align_now, right_open, fwd_move, pick_ok, s_ok;
    logic [COORD_BITS-1:0] sx, sy;

    assign h_p1 = i_head + HB'(1);
    assign h_p2 = i_head + HB'(2);
    assign h_p3 = i_head + HB'(3);

    assign align_now  = !i_aligned;
    assign right_open = !i_walls[h_p1];
    assign fwd_move   = align_now && right_open && !i_fwd_done && !i_walls[i_head];

    // alignment turns: first right turn that leaves a wall on the right
    always_comb begin
        if (i_walls[h_p2]) begin
            h_rot = h_p1;
        end else if (i_walls[h_p3]) begin
            h_rot = h_p2;
        end else if (i_walls[i_head]) begin
            h_rot = h_p3;
        end else begin
            h_rot = i_head;
        end
    end

    assign h_base = (align_now && right_open) ? h_rot : i_head;
    assign b_p1   = h_base + HB'(1);
    assign b_p2   = h_base + HB'(2);
    assign b_p3   = h_base + HB'(3);

    // right, forward, left, back
    always_comb begin
        pick_ok = 1'b1;
        if (!i_walls[b_p1]) begin
            h_pick = b_p1;
        end else if (!i_walls[h_base]) begin
            h_pick = h_base;
        end else if (!i_walls[b_p3]) begin
            h_pick = b_p3;
        end else if (!i_walls[b_p2]) begin
            h_pick = b_p2;
        end else begin
            h_pick  = h_base;
            pick_ok = 1'b0;
        end
    end

    assign d_step = fwd_move ? i_head : h_pick;

    // neighbor cell with grid edge check
    always_comb begin
        sx   = i_x;
        sy   = i_y;
        s_ok = 1'b1;
        case (rhwf_pkg::t_heading'(d_step))
            rhwf_pkg::HEAD_UP: begin
                if (i_y == '0) s_ok = 1'b0;
                else sy = i_y - COORD_BITS'(1);
            end
            rhwf_pkg::HEAD_RIGHT: begin
                if (i_x == '1) s_ok = 1'b0;
                else sx = i_x + COORD_BITS'(1);
            end
            rhwf_pkg::HEAD_DOWN: begin
                if (i_y == '1) s_ok = 1'b0;
                else sy = i_y + COORD_BITS'(1);
            end
            default: begin
                if (i_x == '0) s_ok = 1'b0;
                else sx = i_x - COORD_BITS'(1);
            end
        endcase
    end

    always_comb begin
        o_x            = i_x;
        o_y            = i_y;
        o_head         = i_head;
        o_ctl.status   = rhwf_pkg::STAT_MOVED;
        o_ctl.record   = 1'b0;
        o_ctl.halt     = 1'b0;
        o_ctl.fwd_done = fwd_move ? i_fwd_done : 1'b1;
        o_ctl.aligned  = fwd_move ? i_aligned : 1'b1;
        if (fwd_move) begin
            if (s_ok) begin
                o_x          = sx;
                o_y          = sy;
                o_ctl.status = rhwf_pkg::STAT_ALIGN;
            end else begin
                o_ctl.status = rhwf_pkg::STAT_RANGE;
                o_ctl.halt   = 1'b1;
            end
        end else if (!pick_ok) begin
            o_head       = h_base;
            o_ctl.status = rhwf_pkg::STAT_STUCK;
            o_ctl.halt   = 1'b1;
        end else begin
            o_head = h_pick;
            if (s_ok) begin
                o_x          = sx;
                o_y          = sy;
                o_ctl.record = 1'b1;
            end else begin
                o_ctl.status = rhwf_pkg::STAT_RANGE;
                o_ctl.halt   = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/right_hand_wall_follower_unit.sv
// right_hand_wall_follower_unit: top level of the right-hand wall follower
// depends on rhwf_pkg, rhwf_if, rhwf_move, rhwf_cell
//
//  channel   dir  payload                          moves on
//  i_step    in   wall_up/right/down/left          valid & ready
//  o_res     out  pos_x, pos_y, heading, status    valid & ready
//  i_cfg     in   index, data (start x/y/heading)  valid & ready (ready tied high)
//
//  a step that ends in a normal move waits for its result while the visit
//  token crosses the row of HISTORY_DEPTH history cells, one cell per cycle
//  aligning, stuck and out-of-range steps skip the search; halted steps are dropped
//  reset or any start register write restarts from the start cell, no clearing pass
//  a result waits in a skid register while the output stalls, so the next step
//  can be taken before the previous result is transferred
`default_nettype none

module right_hand_wall_follower_unit #(
    parameter int HISTORY_DEPTH = 256,
    parameter int COORD_BITS    = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rhwf_step_if.sink   i_step,
    rhwf_res_if.source  o_res,
    rhwf_cfg_if.sink    i_cfg
);

    localparam int HB      = rhwf_pkg::HEAD_BITS;
    localparam int SB      = rhwf_pkg::STATUS_BITS;
    localparam int ENTRY_W = 2 * COORD_BITS + HB;
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);

    // architectural state
    logic [COORD_BITS-1:0] r_start_x, n_start_x;
    logic [COORD_BITS-1:0] r_start_y, n_start_y;
    logic [HB-1:0]         r_start_head, n_start_head;
    logic [COORD_BITS-1:0] r_x, n_x;
    logic [COORD_BITS-1:0] r_y, n_y;
    logic [HB-1:0]         r_head, n_head;
    logic                  r_fwd_done, n_fwd_done;
    logic                  r_aligned, n_aligned;
    logic                  r_halted, n_halted;
    logic [CNT_W-1:0]      r_count, n_count;
    rhwf_pkg::t_state      r_state, n_state;

    // skid and output registers
    logic                  r_res_pend, n_res_pend;
    logic [COORD_BITS-1:0] r_res_x, n_res_x;
    logic [COORD_BITS-1:0] r_res_y, n_res_y;
    logic [HB-1:0]         r_res_head, n_res_head;
    logic [SB-1:0]         r_res_status, n_res_status;
    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_out_x, n_out_x;
    logic [COORD_BITS-1:0] r_out_y, n_out_y;
    logic [HB-1:0]         r_out_head, n_out_head;
    logic [SB-1:0]         r_out_status, n_out_status;

    // control
    logic                  w_in_ready;
    logic                  w_step_xfer;
    logic                  w_live;
    logic                  w_exit;
    logic                  w_cfg_xfer;
    logic                  w_cfg_known;
    logic [3:0]            w_walls;
    logic                  w_full;
    logic [SB-1:0]         w_exit_status;

    // move decision
    logic [COORD_BITS-1:0] w_mv_x, w_mv_y;
    logic [HB-1:0]         w_mv_head;
    rhwf_pkg::t_move_ctl   w_mv;

    // token path through the cell row
    rhwf_pkg::t_tok_ctl    w_ctl    [0:HISTORY_DEPTH];
    logic [ENTRY_W-1:0]    w_probe  [0:HISTORY_DEPTH];
    logic [CNT_W-1:0]      w_remain [0:HISTORY_DEPTH];

    // wall vector indexed by compass heading
    assign w_walls = {i_step.wall_left, i_step.wall_down, i_step.wall_right, i_step.wall_up};

    assign w_step_xfer = i_step.valid && w_in_ready;
    assign w_live      = w_step_xfer && !r_halted;
    assign w_cfg_xfer  = i_cfg.valid;
    assign w_exit      = w_ctl[HISTORY_DEPTH].valid;

    rhwf_move #(
        .COORD_BITS (COORD_BITS)
    ) u_move (
        .i_walls    (w_walls),
        .i_x        (r_x),
        .i_y        (r_y),
        .i_head     (r_head),
        .i_fwd_done (r_fwd_done),
        .i_aligned  (r_aligned),
        .o_x        (w_mv_x),
        .o_y        (w_mv_y),
        .o_head     (w_mv_head),
        .o_ctl      (w_mv)
    );

    // a recorded move launches a token carrying the new visit and the fill count
    always_comb begin
        w_ctl[0]        = '0;
        w_ctl[0].valid  = w_live && w_mv.record;
        w_probe[0]      = {w_mv_x, w_mv_y, w_mv_head};
        w_remain[0]     = r_count;
    end

    for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
        rhwf_cell #(
            .ENTRY_BITS (ENTRY_W),
            .CNT_BITS   (CNT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl[g]),
            .i_probe  (w_probe[g]),
            .i_remain (w_remain[g]),
            .o_ctl    (w_ctl[g+1]),
            .o_probe  (w_probe[g+1]),
            .o_remain (w_remain[g+1])
        );
    end

    // outcome once the token leaves the last cell
    assign w_full = (r_count == CNT_W'(HISTORY_DEPTH));
    always_comb begin
        if (w_ctl[HISTORY_DEPTH].hit) begin
            w_exit_status = rhwf_pkg::STAT_LOOP;
        end else if (w_full) begin
            w_exit_status = rhwf_pkg::STAT_FULL;
        end else begin
            w_exit_status = rhwf_pkg::STAT_MOVED;
        end
    end

    // start register decode
    always_comb begin
        n_start_x    = r_start_x;
        n_start_y    = r_start_y;
        n_start_head = r_start_head;
        w_cfg_known  = 1'b1;
        case (rhwf_pkg::t_cfg_reg'(i_cfg.index))
            rhwf_pkg::REG_START_X:       n_start_x    = i_cfg.data;
            rhwf_pkg::REG_START_Y:       n_start_y    = i_cfg.data;
            rhwf_pkg::REG_START_HEADING: n_start_head = i_cfg.data[HB-1:0];
            default:                     w_cfg_known  = 1'b0;
        endcase
        if (!w_cfg_xfer) begin
            n_start_x    = r_start_x;
            n_start_y    = r_start_y;
            n_start_head = r_start_head;
        end
    end

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rhwf_pkg::S_IDLE: begin
                if (w_live && w_mv.record) n_state = rhwf_pkg::S_SEARCH;
            end
            rhwf_pkg::S_SEARCH: begin
                if (w_exit) n_state = rhwf_pkg::S_IDLE;
            end
            default: n_state = rhwf_pkg::S_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        case (r_state)
            rhwf_pkg::S_IDLE: w_in_ready = !r_res_pend;
            default:          w_in_ready = 1'b0;
        endcase
    end

    // datapath next values
    always_comb begin
        n_x          = r_x;
        n_y          = r_y;
        n_head       = r_head;
        n_fwd_done   = r_fwd_done;
        n_aligned    = r_aligned;
        n_halted     = r_halted;
        n_count      = r_count;
        n_res_pend   = r_res_pend;
        n_res_x      = r_res_x;
        n_res_y      = r_res_y;
        n_res_head   = r_res_head;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_head   = r_out_head;
        n_out_status = r_out_status;

        // skid register to output register
        if (r_res_pend && (!r_out_valid || o_res.ready)) begin
            n_out_valid  = 1'b1;
            n_out_x      = r_res_x;
            n_out_y      = r_res_y;
            n_out_head   = r_res_head;
            n_out_status = r_res_status;
            n_res_pend   = 1'b0;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        // step transfer; halted steps are dropped
        if (w_live) begin
            n_x        = w_mv_x;
            n_y        = w_mv_y;
            n_head     = w_mv_head;
            n_fwd_done = w_mv.fwd_done;
            n_aligned  = w_mv.aligned;
            n_halted   = w_mv.halt;
            if (!w_mv.record) begin
                n_res_x      = w_mv_x;
                n_res_y      = w_mv_y;
                n_res_head   = w_mv_head;
                n_res_status = w_mv.status;
                n_res_pend   = 1'b1;
            end
        end

        // history search finished
        if (w_exit) begin
            n_res_x      = r_x;
            n_res_y      = r_y;
            n_res_head   = r_head;
            n_res_status = w_exit_status;
            n_res_pend   = 1'b1;
            if (w_ctl[HISTORY_DEPTH].hit || w_full) begin
                n_halted = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end

        // start register write restarts the walk
        if (w_cfg_xfer && w_cfg_known) begin
            n_x        = n_start_x;
            n_y        = n_start_y;
            n_head     = n_start_head;
            n_fwd_done = 1'b0;
            n_aligned  = 1'b0;
            n_halted   = 1'b0;
            n_count    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_start_head <= rhwf_pkg::START_HEADING_RST;
            r_x          <= '0;
            r_y          <= '0;
            r_head       <= rhwf_pkg::START_HEADING_RST;
            r_fwd_done   <= 1'b0;
            r_aligned    <= 1'b0;
            r_halted     <= 1'b0;
            r_count      <= '0;
            r_state      <= rhwf_pkg::S_IDLE;
            r_res_pend   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_start_x    <= n_start_x;
            r_start_y    <= n_start_y;
            r_start_head <= n_start_head;
            r_x          <= n_x;
            r_y          <= n_y;
            r_head       <= n_head;
            r_fwd_done   <= n_fwd_done;
            r_aligned    <= n_aligned;
            r_halted     <= n_halted;
            r_count      <= n_count;
            r_state      <= n_state;
            r_res_pend   <= n_res_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        r_res_x      <= n_res_x;
        r_res_y      <= n_res_y;
        r_res_head   <= n_res_head;
        r_res_status <= n_res_status;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_head   <= n_out_head;
        r_out_status <= n_out_status;
    end

    assign i_step.ready = w_in_ready;
    assign i_cfg.ready  = 1'b1;
    assign o_res.valid   = r_out_valid;
    assign o_res.pos_x   = r_out_x;
    assign o_res.pos_y   = r_out_y;
    assign o_res.heading = r_out_head;
    assign o_res.status  = r_out_status;

endmodule

`default_nettype wire

// File: design/rhwf_checker.sv
// rhwf_checker: port-level checks for the wall follower, bound to the top level
// depends on rhwf_pkg and right_hand_wall_follower_unit
`default_nettype none

module rhwf_checker #(
    parameter int COORD_BITS = 8
) (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_res_valid,
    input wire logic                             i_res_ready,
    input wire logic [COORD_BITS-1:0]            i_res_pos_x,
    input wire logic [COORD_BITS-1:0]            i_res_pos_y,
    input wire logic [rhwf_pkg::HEAD_BITS-1:0]   i_res_heading,
    input wire logic [rhwf_pkg::STATUS_BITS-1:0] i_res_status
);

    // no result offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid
            && $stable(i_res_pos_x) && $stable(i_res_pos_y)
            && $stable(i_res_heading) && $stable(i_res_status))
        else $error("stalled result changed");

    // out of range only when facing the grid edge
    a_range_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status == rhwf_pkg::STAT_RANGE) |->
            (i_res_heading == rhwf_pkg::HEAD_UP && i_res_pos_y == '0)
            || (i_res_heading == rhwf_pkg::HEAD_RIGHT && i_res_pos_x == '1)
            || (i_res_heading == rhwf_pkg::HEAD_DOWN && i_res_pos_y == '1)
            || (i_res_heading == rhwf_pkg::HEAD_LEFT && i_res_pos_x == '0))
        else $error("out of range away from the edge");

    // a halting result is the last one
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready
            && (i_res_status == rhwf_pkg::STAT_STUCK
                || i_res_status == rhwf_pkg::STAT_LOOP
                || i_res_status == rhwf_pkg::STAT_FULL
                || i_res_status == rhwf_pkg::STAT_RANGE)
        |=> !i_res_valid)
        else $error("result after halt");

endmodule

bind right_hand_wall_follower_unit rhwf_checker #(
    .COORD_BITS (COORD_BITS)
) u_rhwf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_pos_x   (o_res.pos_x),
    .i_res_pos_y   (o_res.pos_y),
    .i_res_heading (o_res.heading),
    .i_res_status  (o_res.status)
);

`default_nettype wire
